// File: sv/tsl_pkg.sv
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types and constants of the two-segment torque linearizer: register
// indexes, reset values, validation limits, widths and the coefficient bundle.
// ----------------------------------------------------------------------------
package tsl_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ZERO_OFFSET = 3'd0;
  localparam cfg_idx_t REG_ADC_SPAN    = 3'd1;
  localparam cfg_idx_t REG_SAT_PERCENT = 3'd2;
  localparam cfg_idx_t REG_KNEE_WEIGHT = 3'd3;
  localparam cfg_idx_t REG_TOP_WEIGHT  = 3'd4;

  // Register widths and reset values
  localparam int OFFSET_W = 10;
  localparam int PCT_W    = 8;
  localparam int KG_W     = 8;

  localparam logic [OFFSET_W-1:0] RST_ZERO_OFFSET = 10'd150;
  localparam logic [OFFSET_W-1:0] RST_ADC_SPAN    = 10'd300;
  localparam logic [PCT_W-1:0]    RST_SAT_PERCENT = 8'd10;
  localparam logic [KG_W-1:0]     RST_KNEE_WEIGHT = 8'd50;
  localparam logic [KG_W-1:0]     RST_TOP_WEIGHT  = 8'd80;

  // Validation limits
  localparam logic [OFFSET_W-1:0] LIM_OFFSET_MIN = 10'd100;
  localparam logic [OFFSET_W-1:0] LIM_OFFSET_MAX = 10'd300;
  localparam logic [OFFSET_W-1:0] LIM_SPAN_MIN   = 10'd50;
  localparam logic [KG_W-1:0]     LIM_KNEE_MIN   = 8'd20;
  localparam logic [KG_W-1:0]     LIM_KNEE_MAX   = 8'd70;
  localparam logic [KG_W-1:0]     LIM_TOP_MAX    = 8'd100;
  localparam logic [KG_W-1:0]     LIM_WEIGHT_GAP = 8'd10;
  localparam logic [PCT_W-1:0]    LIM_PCT_MAX    = 8'd34;
  localparam logic [10:0]         LIM_TOPADC_MIN = 11'd100;
  localparam logic [10:0]         LIM_TOPADC_MAX = 11'd600;

  // Curve constants
  localparam logic [PCT_W-1:0] PCT_FULL   = 8'd100;
  localparam logic [KG_W-1:0]  KG_FULL    = 8'd80;
  localparam int               TORQUE_W   = 8;
  localparam logic [TORQUE_W-1:0] TORQUE_MAX = 8'd160;
  localparam int               FRAC_BITS  = 16;
  localparam logic [31:0]      ROUND_HALF = 32'd32768;

  // Divide by 100 as multiply and shift; exact for dividends below 2^17
  localparam int          RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP_PCT   = 18'd167773;

  // Derived coefficient widths
  localparam int KNEE_W  = 11;
  localparam int SLOPE_W = 32;

  // Shared divider
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 19;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Coefficients handed from the setup unit to the datapath
  typedef struct packed {
    logic [OFFSET_W-1:0] zero_offset;
    logic [KNEE_W-1:0]   knee_adc;
    logic [TORQUE_W-1:0] knee_out;
    logic [SLOPE_W-1:0]  slope_low;
    logic [SLOPE_W-1:0]  slope_high;
    logic                setup_err;
  } tsl_coef_t;

endpackage

// File: sv/tsl_div.sv
// ----------------------------------------------------------------------------
// tsl_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the operands and restarts any division in progress; done pulses for one
// cycle with the quotient.
// ----------------------------------------------------------------------------
module tsl_div
  import tsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  // Shift in the next numerator bit and try the subtract
  assign rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = (rem_sh >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  // A result only follows a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

// File: sv/tsl_setup.sv
// ----------------------------------------------------------------------------
// tsl_setup
// Configuration registers and coefficient sequencer. After reset and after
// every register write it derives the knee with a reciprocal multiply, then
// both Q16 slopes through two divisions on the shared divider, and validates
// the setup.
// ----------------------------------------------------------------------------
module tsl_setup
  import tsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output tsl_coef_t             coef,
  output logic                  busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_KNEE = 4'b0010,
    ST_LOW  = 4'b0100,
    ST_HIGH = 4'b1000
  } setup_state_t;

  setup_state_t state_r;
  logic         start_r;

  logic [OFFSET_W-1:0] off_r;
  logic [OFFSET_W-1:0] span_r;
  logic [PCT_W-1:0]    pct_r;
  logic [KG_W-1:0]     knee_kg_r;
  logic [KG_W-1:0]     top_kg_r;

  logic [17:0]         knee_prod_r;
  logic [KNEE_W-1:0]   knee_r;
  logic [TORQUE_W-1:0] knee_out_r;
  logic [SLOPE_W-1:0]  slope_low_r;
  logic [SLOPE_W-1:0]  slope_high_r;
  logic                err_r;

  logic                 cfg_hit;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  logic [KNEE_W-1:0]    top_adc;
  logic [TORQUE_W-1:0]  knee_out;
  logic [PCT_W-1:0]     pct_rest;
  logic [17:0]          knee_prod;
  logic [35:0]          knee_mul;
  logic [KNEE_W-1:0]    knee_quo;
  logic [KNEE_W-1:0]    knee_nxt;
  logic [KNEE_W-1:0]    d1;
  logic [KNEE_W-1:0]    d2;
  logic [KG_W-1:0]      d80;
  logic [KG_W-1:0]      dw;
  logic [TORQUE_W-1:0]  out_rest;
  logic [15:0]          high_prod;
  logic [DIV_DEN_W-1:0] den_high;
  logic [18:0]          chk_lhs;
  logic [18:0]          chk_rhs;
  logic                 slope_fail;
  logic                 limits_fail;

  // Decode register writes
  always_comb begin
    unique case (cfg_index)
      REG_ZERO_OFFSET, REG_ADC_SPAN, REG_SAT_PERCENT,
      REG_KNEE_WEIGHT, REG_TOP_WEIGHT: cfg_hit = cfg_we;
      default:                         cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= RST_ZERO_OFFSET;
      span_r    <= RST_ADC_SPAN;
      pct_r     <= RST_SAT_PERCENT;
      knee_kg_r <= RST_KNEE_WEIGHT;
      top_kg_r  <= RST_TOP_WEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_OFFSET: off_r     <= cfg_wdata;
        REG_ADC_SPAN:    span_r    <= cfg_wdata;
        REG_SAT_PERCENT: pct_r     <= cfg_wdata[PCT_W-1:0];
        REG_KNEE_WEIGHT: knee_kg_r <= cfg_wdata[KG_W-1:0];
        REG_TOP_WEIGHT:  top_kg_r  <= cfg_wdata[KG_W-1:0];
        default: ;
      endcase
    end
  end

  // Intermediate terms of the derivation
  assign top_adc   = {1'b0, off_r} + {1'b0, span_r};
  assign knee_out  = {knee_kg_r[KG_W-2:0], 1'b0};
  assign pct_rest  = PCT_FULL - pct_r;
  assign knee_prod = span_r * pct_rest;
  assign knee_mul  = knee_prod_r * RECIP_PCT;
  assign knee_quo  = knee_mul[RECIP_SHIFT +: KNEE_W];
  assign knee_nxt  = knee_quo + {1'b0, off_r};
  assign d1        = knee_nxt - {1'b0, off_r};
  assign d2        = top_adc - knee_r;
  assign d80       = KG_FULL - knee_kg_r;
  assign dw        = top_kg_r - knee_kg_r;
  assign out_rest  = TORQUE_MAX - knee_out_r;
  assign high_prod = out_rest * dw;
  assign den_high  = d2 * d80;

  // Second slope must be steeper than the first
  assign chk_lhs    = (knee_r - {1'b0, off_r}) * dw;
  assign chk_rhs    = d2 * knee_kg_r;
  assign slope_fail = (chk_lhs <= chk_rhs);

  // Fixed limits on the registers
  assign limits_fail = (off_r < LIM_OFFSET_MIN) || (off_r > LIM_OFFSET_MAX) ||
                       (span_r < LIM_SPAN_MIN) ||
                       (knee_kg_r < LIM_KNEE_MIN) || (knee_kg_r > LIM_KNEE_MAX) ||
                       (top_kg_r > LIM_TOP_MAX) || (knee_kg_r >= top_kg_r) ||
                       (dw < LIM_WEIGHT_GAP) ||
                       (pct_r == '0) || (pct_r > LIM_PCT_MAX) ||
                       (top_adc < LIM_TOPADC_MIN) || (top_adc > LIM_TOPADC_MAX);

  // Pick the next division for the divider
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (!start_r) begin
      unique case (state_r)
        ST_KNEE: begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'({knee_out, {FRAC_BITS{1'b0}}});
          div_den   = DIV_DEN_W'(d1);
        end
        ST_LOW: begin
          div_start = div_done;
          div_num   = {high_prod, {FRAC_BITS{1'b0}}};
          div_den   = den_high;
        end
        default: ;
      endcase
    end
  end

  tsl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequence the derivation; a write to a used index restarts it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      state_r <= ST_IDLE;
    end else begin
      start_r <= cfg_hit;
      if (start_r) begin
        state_r <= ST_KNEE;
      end else begin
        unique case (state_r)
          ST_KNEE: state_r <= ST_LOW;
          ST_LOW:  if (div_done) state_r <= ST_HIGH;
          ST_HIGH: if (div_done) state_r <= ST_IDLE;
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  // Capture the coefficients as each step completes
  always_ff @(posedge clk) begin
    if (start_r) begin
      knee_prod_r <= knee_prod;
    end else begin
      unique case (state_r)
        ST_KNEE: begin
          knee_r     <= knee_nxt;
          knee_out_r <= knee_out;
        end
        ST_LOW: begin
          if (div_done) slope_low_r <= div_quo;
        end
        ST_HIGH: begin
          if (div_done) begin
            slope_high_r <= div_quo;
            err_r        <= limits_fail || slope_fail;
          end
        end
        default: ;
      endcase
    end
  end

  assign coef.zero_offset = off_r;
  assign coef.knee_adc    = knee_r;
  assign coef.knee_out    = knee_out_r;
  assign coef.slope_low   = slope_low_r;
  assign coef.slope_high  = slope_high_r;
  assign coef.setup_err   = err_r;
  assign busy             = start_r || (state_r != ST_IDLE);

  // Coefficients hold while nothing is being derived or written
  a_coef_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !start_r && !cfg_we) |=> $stable(coef))
    else $error("coefficients changed while setup idle");

endmodule

// File: sv/tsl_datapath.sv
// ----------------------------------------------------------------------------
// tsl_datapath
// Three-register sample pipeline: input register, slope product register and
// result register. Each stage advances on its own, so bubbles close up and
// a new item enters every cycle while results keep draining and setup is idle.
// ----------------------------------------------------------------------------
module tsl_datapath
  import tsl_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsl_coef_t           coef,
  input  logic                setup_busy,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TORQUE_W-1:0] out_torque_level,
  output logic                out_setup_invalid
);

  localparam int XW = (ADC_BITS > KNEE_W) ? ADC_BITS : KNEE_W;
  localparam int PW = XW + SLOPE_W;
  localparam int RW = PW + 1 - FRAC_BITS;

  logic                en_x;
  logic                en_p;
  logic                en_o;

  logic                xv_r;
  logic [ADC_BITS-1:0] x_r;

  logic                pv_r;
  logic [PW-1:0]       prod_r;
  logic                low_r;
  logic                zero_r;
  logic                err_p_r;

  logic                ov_r;
  logic [TORQUE_W-1:0] torque_r;
  logic                inv_r;

  logic [XW-1:0]       x_ext;
  logic [XW-1:0]       off_ext;
  logic [XW-1:0]       knee_ext;
  logic                above;
  logic                low_seg;
  logic [XW-1:0]       diff;
  logic [SLOPE_W-1:0]  slope;
  logic [PW-1:0]       prod_nxt;

  logic [PW:0]         rnd_sum;
  logic [RW-1:0]       rnd;
  logic [RW:0]         level;
  logic [TORQUE_W-1:0] torque_nxt;

  // Stage enables: a stage moves when the next one is empty or moving
  assign en_o     = !ov_r || out_ready;
  assign en_p     = !pv_r || en_o;
  assign en_x     = !xv_r || en_p;
  assign in_ready = en_x && !setup_busy;

  // Segment select and slope product
  assign x_ext    = XW'(x_r);
  assign off_ext  = XW'(coef.zero_offset);
  assign knee_ext = XW'(coef.knee_adc);
  assign above    = (x_ext > off_ext);
  assign low_seg  = (x_ext <= knee_ext);
  assign diff     = low_seg ? (x_ext - off_ext) : (x_ext - knee_ext);
  assign slope    = low_seg ? coef.slope_low : coef.slope_high;
  assign prod_nxt = PW'(diff) * PW'(slope);

  // Round, add the knee output on the upper segment, saturate or force zero
  assign rnd_sum = {1'b0, prod_r} + (PW+1)'(ROUND_HALF);
  assign rnd     = rnd_sum[PW:FRAC_BITS];
  assign level   = {1'b0, rnd} + (low_r ? '0 : (RW+1)'(coef.knee_out));

  always_comb begin
    if (zero_r) begin
      torque_nxt = '0;
    end else if (level > (RW+1)'(TORQUE_MAX)) begin
      torque_nxt = TORQUE_MAX;
    end else begin
      torque_nxt = level[TORQUE_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r <= 1'b0;
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en_x) xv_r <= in_valid && in_ready;
      if (en_p) pv_r <= xv_r;
      if (en_o) ov_r <= pv_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_adc_sample;
    end
    if (en_p && xv_r) begin
      prod_r  <= prod_nxt;
      low_r   <= low_seg;
      zero_r  <= coef.setup_err || !above;
      err_p_r <= coef.setup_err;
    end
    if (en_o && pv_r) begin
      torque_r <= torque_nxt;
      inv_r    <= err_p_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_torque_level  = torque_r;
  assign out_setup_invalid = inv_r;

  // Result stays in range
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_torque_level <= TORQUE_MAX))
    else $error("torque level above saturation");

  // A rejected setup forces zero torque
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_setup_invalid) |-> (out_torque_level == '0))
    else $error("nonzero torque with invalid setup");

  // No item enters while coefficients are being derived
  a_no_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    setup_busy |=> !($past(in_valid) && xv_r && !$past(xv_r)))
    else $error("item accepted during setup");

endmodule

// File: sv/two_segment_torque_linearizer.sv
// ----------------------------------------------------------------------------
// two_segment_torque_linearizer
// Maps a torque-sensor ADC sample onto a two-segment linear curve, 0 to 160.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready; results leave on out_valid/out_ready
//   with torque_level and the setup_invalid flag, one result per sample, in
//   order. A sample passes the input, product and result registers in turn;
//   one sample is accepted every cycle while setup is idle and results drain.
//   The three pipeline registers advance independently, so a stalled receiver
//   first fills the empty stages; in_ready falls once all three hold items.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
//   the user must write them only while no item is in flight, as the block
//   does not enforce it. Reset loads the default calibration. After reset and
//   after every register write, the knee is re-derived by a reciprocal
//   multiply and both slopes by two 32-step divisions on one shared divider;
//   in_ready stays low meanwhile. A write to an unused index is ignored.
//   When the calibration fails validation every sample yields zero torque
//   and setup_invalid is set.
// ----------------------------------------------------------------------------
module two_segment_torque_linearizer
  import tsl_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TORQUE_W-1:0]   out_torque_level,
  output logic                  out_setup_invalid
);

  tsl_coef_t coef;
  logic      setup_busy;

  // Calibration registers and coefficient derivation
  tsl_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef),
    .busy      (setup_busy)
  );

  // Per-sample interpolation pipeline
  tsl_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .coef              (coef),
    .setup_busy        (setup_busy),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_torque_level  (out_torque_level),
    .out_setup_invalid (out_setup_invalid)
  );

endmodule

// File: tb/tb_two_segment_torque_linearizer.sv
// ----------------------------------------------------------------------------
// tb_two_segment_torque_linearizer
// Self-checking bench for the two-segment torque linearizer. Drives ADC
// samples through the valid/ready input, predicts each torque result from a
// local copy of the calibration, and compares every result in order. The
// calibration is changed between phases: corner settings first, then random
// ones, with random idle bursts on both sides of the block.
// ----------------------------------------------------------------------------
module tb_two_segment_torque_linearizer;
  import tsl_pkg::*;

  localparam int ADC_BITS     = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL   = 150;
  localparam int PRINT_CAP    = 40;

  // Indexes past the last register are decoded as spare and ignored
  localparam cfg_idx_t IDX_SPARE_FIRST = REG_TOP_WEIGHT + 1'b1;
  localparam cfg_idx_t IDX_SPARE_LAST  = '1;

  typedef struct packed {
    logic [TORQUE_W-1:0] level;
    logic                bad_cal;
  } torque_result_t;

  typedef struct {
    int unsigned off;
    int unsigned span;
    int unsigned pct;
    int unsigned knee_kg;
    int unsigned top_kg;
  } calib_t;

  // Torque predictor and in-order result checker
  class torque_scoreboard;
    logic [OFFSET_W-1:0] off_reg;
    logic [OFFSET_W-1:0] span_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [KG_W-1:0]     knee_kg_reg;
    logic [KG_W-1:0]     top_kg_reg;
    logic [KNEE_W-1:0]   knee_pos;
    logic [TORQUE_W-1:0] knee_level;
    logic [SLOPE_W-1:0]  gain_low;
    logic [SLOPE_W-1:0]  gain_high;
    logic                cal_bad;
    torque_result_t      expected_torque[$];
    int                  mismatches;
    int                  matched;

    function new();
      off_reg     = RST_ZERO_OFFSET;
      span_reg    = RST_ADC_SPAN;
      pct_reg     = RST_SAT_PERCENT;
      knee_kg_reg = RST_KNEE_WEIGHT;
      top_kg_reg  = RST_TOP_WEIGHT;
      knee_pos    = '0;
      knee_level  = '0;
      gain_low    = '0;
      gain_high   = '0;
      mismatches  = 0;
      matched     = 0;
      rederive();
    endfunction

    // Recompute knee and slopes; keep old coefficients when limits fail
    function void rederive();
      longint unsigned off, span, pct, kw, tw, top, knee, d1, d2, dw, d80;
      off  = off_reg;
      span = span_reg;
      pct  = pct_reg;
      kw   = knee_kg_reg;
      tw   = top_kg_reg;
      top  = off + span;
      cal_bad = 1'b0;
      if (off < 100 || off > 300 || span < 50 || kw < 20 || kw > 70 || tw > 100 ||
          kw >= tw || (tw - kw) < 10 || pct == 0 || pct > 34 || top < 100 ||
          top > 600) begin
        cal_bad = 1'b1;
        return;
      end
      knee       = (span * (100 - pct)) / 100 + off;
      knee_pos   = knee[KNEE_W-1:0];
      knee_level = 8'(2 * kw);
      d1 = longint'(knee_pos) - off;
      gain_low = (d1 != 0) ? 32'((longint'(knee_level) << 16) / d1) : '0;
      d2 = top - knee_pos;
      dw = tw - kw;
      if (d2 != 0 && dw != 0 && kw < 80) begin
        d80 = 80 - kw;
        gain_high = 32'(((160 - longint'(knee_level)) * 65536 * dw) / (d2 * d80));
      end else begin
        gain_high = '0;
      end
      // Second segment must be steeper than the first
      if ((knee - off) * dw <= (top - knee) * kw)
        cal_bad = 1'b1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ZERO_OFFSET: off_reg     = data;
        REG_ADC_SPAN:    span_reg    = data;
        REG_SAT_PERCENT: pct_reg     = data[PCT_W-1:0];
        REG_KNEE_WEIGHT: knee_kg_reg = data[KG_W-1:0];
        REG_TOP_WEIGHT:  top_kg_reg  = data[KG_W-1:0];
        default:         return;
      endcase
      rederive();
    endfunction

    // Queue the torque expected for one accepted sample
    function void note_sample(logic [ADC_BITS-1:0] sample);
      longint unsigned x, r;
      torque_result_t res;
      x = sample;
      r = 0;
      if (!cal_bad && x > off_reg) begin
        if (x <= knee_pos)
          r = ((x - off_reg) * gain_low + 32768) >> 16;
        else
          r = knee_level + (((x - knee_pos) * gain_high + 32768) >> 16);
        if (r > 160)
          r = 160;
      end
      res.level   = r[TORQUE_W-1:0];
      res.bad_cal = cal_bad;
      expected_torque.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Compare one result with the oldest expectation
    task check_result(logic [TORQUE_W-1:0] level, logic bad_cal);
      torque_result_t want;
      if (expected_torque.size() == 0) begin
        report_mismatch($sformatf("unexpected result level=%0d invalid=%0b", level, bad_cal));
        return;
      end
      want = expected_torque.pop_front();
      if (level !== want.level)
        report_mismatch($sformatf("torque_level got %0d want %0d", level, want.level));
      if (bad_cal !== want.bad_cal)
        report_mismatch($sformatf("setup_invalid got %0b want %0b", bad_cal, want.bad_cal));
      if (level === want.level && bad_cal === want.bad_cal)
        matched++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADC_BITS-1:0]   in_adc_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [TORQUE_W-1:0]   out_torque_level;
  logic                  out_setup_invalid;

  torque_scoreboard sb = new();
  bit               idle_on  = 1'b0;
  bit               stall_on = 1'b0;
  int               cycle_count = 0;

  two_segment_torque_linearizer #(.ADC_BITS(ADC_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_torque_level  (out_torque_level),
    .out_setup_invalid (out_setup_invalid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               sb.expected_torque.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: hold ready low in random bursts while stalls are enabled
  initial begin
    int n;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Outputs are stable between edges; a handshake seen here completes next edge
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_torque_level, out_setup_invalid);
    end
  end

  // Present one item and hold it until accepted
  task automatic send_sample(logic [ADC_BITS-1:0] sample);
    bit taken;
    in_valid      <= 1'b1;
    in_adc_sample <= sample;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_sample(sample);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Load a full calibration; 8-bit registers get junk in the unused top bits
  task automatic apply_setting(calib_t c);
    put_reg(REG_ZERO_OFFSET, c.off[OFFSET_W-1:0]);
    put_reg(REG_ADC_SPAN, c.span[OFFSET_W-1:0]);
    put_reg(REG_SAT_PERCENT, {2'($urandom), c.pct[PCT_W-1:0]});
    put_reg(REG_KNEE_WEIGHT, {2'($urandom), c.knee_kg[KG_W-1:0]});
    if ($urandom_range(0, 2) == 0)
      put_reg(cfg_idx_t'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
              CFG_DATA_W'($urandom));
    put_reg(REG_TOP_WEIGHT, {2'($urandom), c.top_kg[KG_W-1:0]});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_torque.size() != 0)
      @(posedge clk);
  endtask

  // Bias samples toward the offset, the knee and the top of the span
  function automatic logic [ADC_BITS-1:0] pick_sample();
    int v;
    int top;
    top = int'(sb.off_reg) + int'(sb.span_reg);
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom_range(0, 1023);
      2, 3:    v = int'(sb.off_reg) + $urandom_range(0, 6) - 3;
      4, 5:    v = int'(sb.knee_pos) + $urandom_range(0, 6) - 3;
      6:       v = top + $urandom_range(0, 40) - 10;
      default: v = $urandom_range(sb.off_reg, (top > 1023) ? 1023 : top);
    endcase
    if (v < 0)
      v = 0;
    if (v > 1023)
      v = 1023;
    return ADC_BITS'(v);
  endfunction

  task automatic run_samples(int count);
    for (int i = 0; i < count; i++) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      send_sample(pick_sample());
    end
    in_valid <= 1'b0;
  endtask

  // Mostly well-formed calibrations, some raw register noise
  function automatic calib_t random_cal();
    calib_t c;
    if ($urandom_range(0, 4) == 0) begin
      c.off     = $urandom_range(0, 1023);
      c.span    = $urandom_range(0, 1023);
      c.pct     = $urandom_range(0, 255);
      c.knee_kg = $urandom_range(0, 255);
      c.top_kg  = $urandom_range(0, 255);
    end else begin
      c.off     = $urandom_range(100, 300);
      c.span    = $urandom_range(50, 600 - c.off);
      c.pct     = $urandom_range(1, 34);
      c.knee_kg = $urandom_range(20, 70);
      c.top_kg  = $urandom_range(c.knee_kg + 10, 100);
    end
    return c;
  endfunction

  initial begin
    logic [ADC_BITS-1:0] reset_samples[16];
    calib_t corner_cals[9];
    int sent;
    int settings;
    int rejected;

    reset_samples = '{10'd0, 10'd1023, 10'd149, 10'd150, 10'd151, 10'd419, 10'd420,
                      10'd421, 10'd449, 10'd450, 10'd451, 10'd600, 10'd285, 10'd512,
                      10'd341, 10'd682};
    // Extremes, rejected limits and a steep first segment
    corner_cals = '{'{100, 50, 1, 20, 100}, '{300, 300, 1, 70, 100},
                    '{300, 300, 34, 70, 80}, '{1023, 1023, 255, 255, 255},
                    '{0, 0, 0, 0, 0}, '{150, 300, 35, 50, 80},
                    '{150, 300, 10, 50, 59}, '{200, 400, 20, 40, 101},
                    '{200, 49, 10, 40, 80}};
    sent     = 0;
    settings = 1;
    rejected = 0;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ZERO_OFFSET;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_adc_sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: offset, knee and top edges
    foreach (reset_samples[i])
      send_sample(reset_samples[i]);
    in_valid <= 1'b0;

    // Corner calibrations, then random ones until the item budget is spent
    foreach (corner_cals[i]) begin
      drain();
      apply_setting(corner_cals[i]);
      settings++;
      rejected += sb.cal_bad;
      idle_on  = (i % 3 != 0);
      stall_on = (i % 2 == 0);
      run_samples(12);
      sent += 12;
    end
    while (sent < RANDOM_ITEMS) begin
      drain();
      apply_setting(random_cal());
      settings++;
      rejected += sb.cal_bad;
      idle_on  = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      stall_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      run_samples(40);
      sent += 40;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d samples across %0d calibrations (%0d rejected), %0d results matched",
             sent + 16, settings, rejected, sb.matched);
    if (sb.mismatches == 0 && sb.expected_torque.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
